FILE: hdl/feistel_block_cipher_16bit_sbox_unit_assert.svh
// Assertion macros shared by the Feistel S-box cipher modules.
// No dependencies; included inside module bodies after the logic.
`ifndef FEISTEL_BLOCK_CIPHER_16BIT_SBOX_UNIT_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_16BIT_SBOX_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define FBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/fbc_pkg.sv
// Shared types, constants and round function for the Feistel S-box cipher.
// No dependencies; imported by every module of the block.
package fbc_pkg;

    localparam int ROUNDS    = 4;
    localparam int HALF_W    = 16;
    localparam int BLOCK_W   = 2 * HALF_W;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_SLOTS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SBOX_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SBOX_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_KEY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_KEY = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } fbc_word_t;

    function automatic logic [3:0] sbox_lookup(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [4:0]       idx
    );
        logic [CFG_W-1:0] bank;
        bank = idx[4] ? hi : lo;
        return bank[{idx[3:0], 2'b00} +: 4];
    endfunction

    function automatic logic [HALF_W-1:0] round_f(
        input logic [CFG_W-1:0]  lo,
        input logic [CFG_W-1:0]  hi,
        input logic [HALF_W-1:0] x
    );
        logic [HALF_W-1:0] p;
        p[3:0]   = sbox_lookup(lo, hi, x[4:0]);
        p[7:4]   = sbox_lookup(lo, hi, x[8:4]);
        p[11:8]  = sbox_lookup(lo, hi, x[12:8]);
        p[15:12] = sbox_lookup(lo, hi, {x[0], x[15:12]});
        // rotate right by three
        return {p[2:0], p[15:3]};
    endfunction

endpackage

FILE: hdl/feistel_block_cipher_16bit_sbox_unit.sv
// Top level of the four-round Feistel cipher on 32-bit blocks of two 16-bit halves, with a configurable S-box.
// Depends on fbc_pkg, fbc_cfg, fbc_round and the assertion macro header.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in       | in        | in_valid / in_ready   | cmd, block_in
//   out      | out       | out_valid / out_ready | block_out
//
// One round per pipeline stage, ROUNDS stages: a word passes through the stage registers in
// round order before it leaves, and a new word is taken every cycle while the output drains.
// Each stage's register holds its word when the next stage stalls; a stage
// refills in the same cycle that it drains. The config port is always ready.
// Reset clears all valid bits and zeroes the S-box and key registers.
module feistel_block_cipher_16bit_sbox_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [fbc_pkg::BLOCK_W-1:0]   block_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fbc_pkg::BLOCK_W-1:0]   block_out
);
    import fbc_pkg::*;

    logic [CFG_W-1:0] sbox_lo;
    logic [CFG_W-1:0] sbox_hi;
    logic [CFG_W-1:0] enc_keys;
    logic [CFG_W-1:0] dec_keys;

    logic      stg_valid [0:ROUNDS];
    logic      stg_ready [0:ROUNDS];
    fbc_word_t stg_word  [0:ROUNDS];

    fbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sbox_lo   (sbox_lo),
        .sbox_hi   (sbox_hi),
        .enc_keys  (enc_keys),
        .dec_keys  (dec_keys)
    );

    assign stg_valid[0]      = in_valid;
    assign in_ready          = stg_ready[0];
    assign stg_word[0].cmd   = cmd;
    assign stg_word[0].left  = block_in[BLOCK_W-1:HALF_W];
    assign stg_word[0].right = block_in[HALF_W-1:0];

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        localparam int SLOT = r % KEY_SLOTS;

        fbc_round u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[r]),
            .up_ready (stg_ready[r]),
            .up_word  (stg_word[r]),
            .dn_valid (stg_valid[r+1]),
            .dn_ready (stg_ready[r+1]),
            .dn_word  (stg_word[r+1]),
            .sbox_lo  (sbox_lo),
            .sbox_hi  (sbox_hi),
            .enc_key  (enc_keys[SLOT*HALF_W +: HALF_W]),
            .dec_key  (dec_keys[SLOT*HALF_W +: HALF_W])
        );
    end

    // final swap of the halves
    assign stg_ready[ROUNDS] = out_ready;
    assign out_valid         = stg_valid[ROUNDS];
    assign block_out         = {stg_word[ROUNDS].right, stg_word[ROUNDS].left};

`include "feistel_block_cipher_16bit_sbox_unit_assert.svh"

    `FBC_ASSERT_NOW(a_ready_when_out_free, clk, rst_n, out_ready, in_ready)
    `FBC_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(block_out))
    `FBC_ASSERT_NOW(a_block_when_full, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

FILE: hdl/fbc_cfg.sv
// Configuration register file: S-box banks and both round key sets.
// Depends on fbc_pkg.
module fbc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]     cfg_data,
    output logic [fbc_pkg::CFG_W-1:0]     sbox_lo,
    output logic [fbc_pkg::CFG_W-1:0]     sbox_hi,
    output logic [fbc_pkg::CFG_W-1:0]     enc_keys,
    output logic [fbc_pkg::CFG_W-1:0]     dec_keys
);
    import fbc_pkg::*;

    logic [CFG_W-1:0] sbox_lo_reg;
    logic [CFG_W-1:0] sbox_hi_reg;
    logic [CFG_W-1:0] enc_keys_reg;
    logic [CFG_W-1:0] dec_keys_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbox_lo_reg  <= '0;
            sbox_hi_reg  <= '0;
            enc_keys_reg <= '0;
            dec_keys_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SBOX_LO: sbox_lo_reg  <= cfg_data;
                CFG_SBOX_HI: sbox_hi_reg  <= cfg_data;
                CFG_ENC_KEY: enc_keys_reg <= cfg_data;
                CFG_DEC_KEY: dec_keys_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sbox_lo  = sbox_lo_reg;
    assign sbox_hi  = sbox_hi_reg;
    assign enc_keys = enc_keys_reg;
    assign dec_keys = dec_keys_reg;

endmodule

FILE: hdl/fbc_round.sv
// One Feistel round as a pipeline stage with its own word register.
// Depends on fbc_pkg and the assertion macro header.
module fbc_round (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  fbc_pkg::fbc_word_t         up_word,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output fbc_pkg::fbc_word_t         dn_word,
    input  logic [fbc_pkg::CFG_W-1:0]  sbox_lo,
    input  logic [fbc_pkg::CFG_W-1:0]  sbox_hi,
    input  logic [fbc_pkg::HALF_W-1:0] enc_key,
    input  logic [fbc_pkg::HALF_W-1:0] dec_key
);
    import fbc_pkg::*;

    logic              valid_reg;
    fbc_word_t         word_reg;
    fbc_word_t         word_next;
    logic [HALF_W-1:0] key;

    // advance when empty or when the next stage takes our word
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        key             = up_word.cmd ? dec_key : enc_key;
        word_next.cmd   = up_word.cmd;
        word_next.left  = up_word.right;
        word_next.right = up_word.left ^ round_f(sbox_lo, sbox_hi, up_word.right ^ key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

`include "feistel_block_cipher_16bit_sbox_unit_assert.svh"

    `FBC_ASSERT_NEXT(a_stall_holds, clk, rst_n, valid_reg && !dn_ready,
                     valid_reg && $stable(word_reg))
    `FBC_ASSERT_NEXT(a_take_fills, clk, rst_n, up_valid && up_ready, valid_reg)
    `FBC_ASSERT_NEXT(a_drain_empties, clk, rst_n, valid_reg && dn_ready && !up_valid,
                     !valid_reg)

endmodule
